// File: design/assert_macros.svh
// Assertion macros shared by the RTL of the UART ADC line parser.
// No dependencies; SYNTH builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// a holds -> b holds in the same cycle
`define ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");
// a holds -> b holds in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPL(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// File: design/uadc_pkg.sv
`timescale 1ns / 1ps
// Types, constants and helper functions for the UART ADC line parser.
// No dependencies.
package uadc_pkg;

  localparam int LINE_LIMIT_DEFAULT = 64;

  localparam int ACC_W = 17;  // 16-bit value plus saturation flag bit

  localparam logic [ACC_W-1:0] ACC_MAX  = 17'd65535;
  localparam logic [ACC_W-1:0] ACC_OVER = 17'd65536;

  // characters
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [3:0] {
    PH_A    = 4'd0,
    PH_D    = 4'd1,
    PH_C    = 4'd2,
    PH_EQ1  = 4'd3,
    PH_ADC0 = 4'd4,
    PH_ADC  = 4'd5,
    PH_M    = 4'd6,
    PH_V    = 4'd7,
    PH_EQ2  = 4'd8,
    PH_MV0  = 4'd9,
    PH_MV   = 4'd10,
    PH_DONE = 4'd11
  } phase_t;

  typedef enum logic [1:0] {
    EV_SAMPLE    = 2'd0,
    EV_MALFORMED = 2'd1,
    EV_TOO_LONG  = 2'd2,
    EV_RX_FAULT  = 2'd3
  } event_kind_t;

  typedef struct packed {
    phase_t           phase;
    logic [ACC_W-1:0] adc;
    logic [ACC_W-1:0] mv;
    logic             bad;
  } parse_state_t;

  typedef struct packed {
    event_kind_t kind;
    logic [15:0] adc;
    logic [15:0] mv;
    logic        rec;
    logic [31:0] err;
  } result_t;

  // acc*10 + d, sticking at ACC_OVER once past 65535
  function automatic logic [ACC_W-1:0] acc_digit(input logic [ACC_W-1:0] acc,
                                                 input logic [3:0] d);
    logic [20:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {17'd0, d};
    if (acc > ACC_MAX || v > {4'd0, ACC_MAX}) begin
      return ACC_OVER;
    end
    return v[ACC_W-1:0];
  endfunction

endpackage

// File: design/uart_adc_millivolt_line_parser.sv
`timescale 1ns / 1ps
// Top level of the UART ADC / millivolt line parser: line tracking, events,
// error count and a two-entry result queue. Depends on uadc_pkg, uadc_parse.
//
// Takes one UART byte per transfer and parses lines of the form
// "ADC=<digits>,MV=<digits>" terminated by CR or LF, each value 0..65535.
// A new byte can be accepted on every clock while in_stall is low; the parser
// state update (prefix match, multiply-by-ten digit accumulate) is one pass
// of logic between the state registers and the
// result queue. Results go into a two-entry queue, so input keeps flowing
// while one result waits for the downstream side; in_stall rises only when
// both queue entries are occupied. A result enters the queue the cycle after
// the byte that caused it and shows on out_valid then if the queue was empty,
// otherwise once the result ahead of it has transferred. Events: a sample
// (or a malformed-line event) at each non-empty line end, an overlong-line
// event when a line would pass LINE_LIMIT-1 bytes (the line is dropped and
// parsing restarts), and a receive-fault event for each byte flagged by
// rx_fault (byte dropped, state untouched). Empty lines produce nothing.
// error_count carries the running total of malformed plus overlong lines,
// wrapping at 32 bits. recording_enable is written through the cfg channel
// (always ready) and should only change while the block is idle; it sets
// record_flag on samples.
`include "assert_macros.svh"

module uart_adc_millivolt_line_parser #(
  parameter int LINE_LIMIT = uadc_pkg::LINE_LIMIT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // byte input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        rx_fault,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_kind,
  output logic [15:0] adc_value,
  output logic [15:0] millivolt_value,
  output logic        record_flag,
  output logic [31:0] error_count,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        recording_enable
);

  // line_count tops out at LINE_LIMIT-1
  localparam int CNT_W = $clog2(LINE_LIMIT);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LINE_LIMIT - 1);

  localparam uadc_pkg::parse_state_t PARSE_IDLE = '{
    phase: uadc_pkg::PH_A,
    adc:   '0,
    mv:    '0,
    bad:   1'b0
  };

  // ---------------------------------------------------------------- state
  logic                   rec_en;
  logic [CNT_W-1:0]       line_count, line_count_next;
  uadc_pkg::parse_state_t pst, pst_next, pst_step;
  logic [31:0]            err_total, err_total_next;

  // result queue: slot0 is the head
  uadc_pkg::result_t q0, q1;
  logic [1:0]        q_cnt;

  // ---------------------------------------------------------------- handshakes
  logic accept, pop, push;
  uadc_pkg::result_t res;

  assign in_stall  = (q_cnt == 2'd2);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (q_cnt != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------- parse step
  uadc_parse u_parse (
    .cur     (pst),
    .rx_byte (rx_byte),
    .nxt     (pst_step)
  );

  // per-byte decision: fault, terminator, ordinary byte, or overflow of line
  logic is_term, line_ok, produce;

  assign is_term = (rx_byte == uadc_pkg::CH_LF) || (rx_byte == uadc_pkg::CH_CR);
  assign line_ok = !pst.bad
                   && (pst.phase == uadc_pkg::PH_MV || pst.phase == uadc_pkg::PH_DONE)
                   && !pst.adc[uadc_pkg::ACC_W-1] && !pst.mv[uadc_pkg::ACC_W-1];

  always_comb begin
    line_count_next = line_count;
    pst_next        = pst;
    err_total_next  = err_total;
    produce         = 1'b0;
    res.kind        = uadc_pkg::EV_RX_FAULT;
    res.adc         = '0;
    res.mv          = '0;
    res.rec         = 1'b0;
    priority if (rx_fault) begin
      produce = 1'b1;
    end else if (is_term) begin
      if (line_count != '0) begin
        produce         = 1'b1;
        line_count_next = '0;
        pst_next        = PARSE_IDLE;
        if (line_ok) begin
          res.kind = uadc_pkg::EV_SAMPLE;
          res.adc  = pst.adc[15:0];
          res.mv   = pst.mv[15:0];
          res.rec  = rec_en;
        end else begin
          res.kind       = uadc_pkg::EV_MALFORMED;
          err_total_next = err_total + 32'd1;
        end
      end
    end else if (line_count < CNT_LAST) begin
      line_count_next = line_count + CNT_W'(1);
      pst_next        = pst_step;
    end else begin
      // line hit the length limit: drop it and restart
      produce         = 1'b1;
      line_count_next = '0;
      pst_next        = PARSE_IDLE;
      res.kind        = uadc_pkg::EV_TOO_LONG;
      err_total_next  = err_total + 32'd1;
    end
    res.err = err_total_next;
  end

  assign push = accept && produce;

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_en     <= 1'b0;
      line_count <= '0;
      pst        <= PARSE_IDLE;
      err_total  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) rec_en <= recording_enable;
      if (accept) begin
        line_count <= line_count_next;
        pst        <= pst_next;
        err_total  <= err_total_next;
      end
    end
  end

  // queue occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= 2'd0;
    end else begin
      if (push && !pop) q_cnt <= q_cnt + 2'd1;
      else if (pop && !push) q_cnt <= q_cnt - 2'd1;
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    if (pop) begin
      if (push) begin
        if (q_cnt == 2'd2) begin
          q0 <= q1;
          q1 <= res;
        end else begin
          q0 <= res;
        end
      end else begin
        q0 <= q1;
      end
    end else if (push) begin
      if (q_cnt == 2'd0) q0 <= res;
      else q1 <= res;
    end
  end

  assign event_kind      = q0.kind;
  assign adc_value       = q0.adc;
  assign millivolt_value = q0.mv;
  assign record_flag     = q0.rec;
  assign error_count     = q0.err;

  // ---------------------------------------------------------------- checks
  `ASSERT_IMPL(a_qcnt_range, clk, rst, 1'b1, q_cnt != 2'd3)
  `ASSERT_IMPL(a_line_range, clk, rst, 1'b1, line_count <= CNT_LAST)
  `ASSERT_NEXT(a_fault_shows, clk, rst, accept && rx_fault, out_valid)
  `ASSERT_NEXT(a_err_hold, clk, rst, !accept, $stable(err_total))

endmodule

// File: design/uadc_parse.sv
`timescale 1ns / 1ps
// One-byte step of the line parser: prefix matching and digit accumulation.
// Depends on uadc_pkg.
module uadc_parse (
  input  uadc_pkg::parse_state_t cur,
  input  logic [7:0]             rx_byte,
  output uadc_pkg::parse_state_t nxt
);

  logic       dig;
  logic [3:0] d;

  assign dig = (rx_byte >= uadc_pkg::CH_ZERO) && (rx_byte <= uadc_pkg::CH_NINE);
  assign d   = rx_byte[3:0];

  always_comb begin
    nxt = cur;
    if (!cur.bad) begin
      unique case (cur.phase)
        uadc_pkg::PH_A: begin
          if (rx_byte == uadc_pkg::CH_A) nxt.phase = uadc_pkg::PH_D;
          else nxt.bad = 1'b1;
        end
        uadc_pkg::PH_D: begin
          if (rx_byte == uadc_pkg::CH_D) nxt.phase = uadc_pkg::PH_C;
          else nxt.bad = 1'b1;
        end
        uadc_pkg::PH_C: begin
          if (rx_byte == uadc_pkg::CH_C) nxt.phase = uadc_pkg::PH_EQ1;
          else nxt.bad = 1'b1;
        end
        uadc_pkg::PH_EQ1: begin
          if (rx_byte == uadc_pkg::CH_EQ) nxt.phase = uadc_pkg::PH_ADC0;
          else nxt.bad = 1'b1;
        end
        uadc_pkg::PH_ADC0: begin
          if (dig) begin
            nxt.adc   = uadc_pkg::acc_digit(cur.adc, d);
            nxt.phase = uadc_pkg::PH_ADC;
          end else begin
            nxt.bad = 1'b1;
          end
        end
        uadc_pkg::PH_ADC: begin
          if (dig) nxt.adc = uadc_pkg::acc_digit(cur.adc, d);
          else if (rx_byte == uadc_pkg::CH_COMMA) nxt.phase = uadc_pkg::PH_M;
          else nxt.bad = 1'b1;
        end
        uadc_pkg::PH_M: begin
          if (rx_byte == uadc_pkg::CH_M) nxt.phase = uadc_pkg::PH_V;
          else nxt.bad = 1'b1;
        end
        uadc_pkg::PH_V: begin
          if (rx_byte == uadc_pkg::CH_V) nxt.phase = uadc_pkg::PH_EQ2;
          else nxt.bad = 1'b1;
        end
        uadc_pkg::PH_EQ2: begin
          if (rx_byte == uadc_pkg::CH_EQ) nxt.phase = uadc_pkg::PH_MV0;
          else nxt.bad = 1'b1;
        end
        uadc_pkg::PH_MV0: begin
          if (dig) begin
            nxt.mv    = uadc_pkg::acc_digit(cur.mv, d);
            nxt.phase = uadc_pkg::PH_MV;
          end else begin
            nxt.bad = 1'b1;
          end
        end
        uadc_pkg::PH_MV: begin
          if (dig) nxt.mv = uadc_pkg::acc_digit(cur.mv, d);
          else if (rx_byte == uadc_pkg::CH_NUL) nxt.phase = uadc_pkg::PH_DONE;
          else nxt.bad = 1'b1;
        end
        uadc_pkg::PH_DONE: begin
          // text ended by a zero byte; rest of line ignored
        end
        default: begin
          nxt.bad = 1'b1;
        end
      endcase
    end
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for uart_adc_millivolt_line_parser: directed lines, then random
// line traffic against a cycle-free line-parse predictor. Depends on uadc_pkg and the RTL.
module testbench;
  import uadc_pkg::*;

  localparam int LINE_LIMIT     = LINE_LIMIT_DEFAULT;
  localparam int RANDOM_ITEMS   = 1500;
  localparam int NUM_PHASES     = 6;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 4;   // result enters the result queue in the cycle after its byte

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT pins. Every input has a known value from time 0.
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        rx_fault = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  event_kind;
  logic [15:0] adc_value;
  logic [15:0] millivolt_value;
  logic        record_flag;
  logic [31:0] error_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        recording_enable = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  uart_adc_millivolt_line_parser #(
    .LINE_LIMIT(LINE_LIMIT)
  ) u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .rx_byte         (rx_byte),
    .rx_fault        (rx_fault),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .event_kind      (event_kind),
    .adc_value       (adc_value),
    .millivolt_value (millivolt_value),
    .record_flag     (record_flag),
    .error_count     (error_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .recording_enable(recording_enable)
  );

  // ---------------------------------------------------------------------------
  // Line-parse predictor: its own copy of the parser state and the register.
  // ---------------------------------------------------------------------------
  int unsigned line_len;
  phase_t      cur_phase;
  int unsigned adc_sum;
  int unsigned mv_sum;
  bit          line_broken;
  logic [31:0] err_tally;
  bit          rec_on;

  result_t     events_due[$];   // predicted events, oldest first
  int          mismatches = 0;
  int          items_sent = 0;

  function automatic void start_line();
    line_len    = 0;
    cur_phase   = PH_A;
    adc_sum     = 0;
    mv_sum      = 0;
    line_broken = 1'b0;
  endfunction

  // acc*10 + digit, pinned at ACC_OVER once the value leaves 16 bits
  function automatic int unsigned decimal_shift_in(int unsigned acc, logic [7:0] ch);
    int unsigned v;
    if (acc > ACC_MAX) return ACC_OVER;
    v = acc * 10 + (ch - CH_ZERO);
    return (v > ACC_MAX) ? ACC_OVER : v;
  endfunction

  function automatic void expect_char(logic [7:0] b, logic [7:0] want, phase_t nxt);
    if (b == want) cur_phase = nxt;
    else line_broken = 1'b1;
  endfunction

  function automatic void scan_char(logic [7:0] b);
    bit dig;
    dig = (b >= CH_ZERO) && (b <= CH_NINE);
    if (line_broken) return;
    case (cur_phase)
      PH_A:   expect_char(b, CH_A, PH_D);
      PH_D:   expect_char(b, CH_D, PH_C);
      PH_C:   expect_char(b, CH_C, PH_EQ1);
      PH_EQ1: expect_char(b, CH_EQ, PH_ADC0);
      PH_ADC0: begin
        if (dig) begin
          adc_sum   = decimal_shift_in(adc_sum, b);
          cur_phase = PH_ADC;
        end else line_broken = 1'b1;
      end
      PH_ADC: begin
        if (dig) adc_sum = decimal_shift_in(adc_sum, b);
        else if (b == CH_COMMA) cur_phase = PH_M;
        else line_broken = 1'b1;
      end
      PH_M:   expect_char(b, CH_M, PH_V);
      PH_V:   expect_char(b, CH_V, PH_EQ2);
      PH_EQ2: expect_char(b, CH_EQ, PH_MV0);
      PH_MV0: begin
        if (dig) begin
          mv_sum    = decimal_shift_in(mv_sum, b);
          cur_phase = PH_MV;
        end else line_broken = 1'b1;
      end
      PH_MV: begin
        if (dig) mv_sum = decimal_shift_in(mv_sum, b);
        else if (b == CH_NUL) cur_phase = PH_DONE;  // NUL ends the text
        else line_broken = 1'b1;
      end
      PH_DONE: ;                                   // tail after NUL is ignored
      default: line_broken = 1'b1;
    endcase
  endfunction

  // One byte in; returns 1 with the event it raises, if any.
  function automatic bit parse_rx_byte(logic [7:0] b, logic f, output result_t r);
    bit ok;
    r = '0;
    if (f) begin
      // faulted byte: dropped, state untouched
      r.kind = EV_RX_FAULT;
      r.err  = err_tally;
      return 1'b1;
    end
    if (b == CH_LF || b == CH_CR) begin
      if (line_len == 0) return 1'b0;              // empty line, silent
      ok = !line_broken && (cur_phase == PH_MV || cur_phase == PH_DONE) &&
           adc_sum <= ACC_MAX && mv_sum <= ACC_MAX;
      if (ok) begin
        r.kind = EV_SAMPLE;
        r.adc  = adc_sum[15:0];
        r.mv   = mv_sum[15:0];
        r.rec  = rec_on;
      end else begin
        err_tally++;
        r.kind = EV_MALFORMED;
      end
      r.err = err_tally;
      start_line();
      return 1'b1;
    end
    if (line_len < LINE_LIMIT - 1) begin
      line_len++;
      scan_char(b);
      return 1'b0;
    end
    // byte would overfill the line: drop it all and start over
    start_line();
    err_tally++;
    r.kind = EV_TOO_LONG;
    r.err  = err_tally;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Byte sender: bursts of random length, random gaps between them.
  // The payload is held until the transfer; valid never looks at stall.
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_byte(input logic [7:0] b, input logic f, input bit typed,
                           input result_t want);
    bit      hit;
    result_t r;
    rx_byte  <= b;
    rx_fault <= f;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    hit = parse_rx_byte(b, f, r);
    if (hit) events_due.push_back(typed ? want : r);
    items_sent++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      // mostly short bursts, now and then a long stretch with no gaps
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 24);
    end else begin
      burst_left--;
    end
  endtask

  // Register write; only called with nothing in flight.
  task automatic write_recording(input logic v);
    recording_enable <= v;
    cfg_valid        <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rec_on = v;
  endtask

  // Wait for every predicted event, then let the bench settle in case the last
  // byte raised nothing but is still being absorbed.
  task automatic drain_events();
    in_valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Random line builder
  // ---------------------------------------------------------------------------
  logic [7:0] line_buf[$];

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic logic [7:0] non_term_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CH_LF || b == CH_CR) b = CH_ZERO;
    return b;
  endfunction

  function automatic int unsigned pick_value();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 9);
      1:       return $urandom_range(65530, 65540);   // around the 16-bit edge
      2:       return $urandom_range(65536, 9999999);  // saturates
      3:       return $urandom_range(0, 999);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic void put_number(int unsigned v);
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) line_buf.push_back(CH_ZERO);
    put_text($sformatf("%0d", v));
  endfunction

  function automatic void build_line();
    int kind;
    int n;
    line_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 80 && kind < 88) begin
      // noise, possibly nothing at all
      n = $urandom_range(0, 12);
      repeat (n) line_buf.push_back(non_term_byte());
    end else if (kind >= 88 && kind < 94) begin
      // runs near or past the length limit
      put_text("ADC=");
      n = $urandom_range(LINE_LIMIT - 6, LINE_LIMIT + 16);
      repeat (n) line_buf.push_back(($urandom_range(0, 3) == 0) ? non_term_byte()
                                    : CH_ZERO + 8'($urandom_range(0, 9)));
    end else begin
      put_text("ADC=");
      put_number(pick_value());
      put_text(",MV=");
      put_number(pick_value());
      if ($urandom_range(0, 5) == 0) begin
        line_buf.push_back(CH_NUL);
        repeat ($urandom_range(0, 5)) line_buf.push_back(non_term_byte());
      end
      if (kind >= 55 && kind < 70) begin
        // one byte trashed, maybe into a terminator that splits the line
        line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (kind >= 70 && kind < 80) begin
        n = $urandom_range(0, line_buf.size() - 1);
        while (line_buf.size() > n) void'(line_buf.pop_back());
      end else if (kind >= 94) begin
        // pad the ADC field with leading zeros up to just under or right at the limit
        n = $urandom_range(LINE_LIMIT - 2, LINE_LIMIT);
        while (line_buf.size() < n) line_buf.insert(4, CH_ZERO);
      end
    end
    case ($urandom_range(0, 3))
      0: line_buf.push_back(CH_LF);
      1: line_buf.push_back(CH_CR);
      2: begin
        line_buf.push_back(CH_CR);
        line_buf.push_back(CH_LF);
      end
      default: begin
        line_buf.push_back(CH_LF);
        line_buf.push_back(CH_LF);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. In the text '#' stands for NUL, '~' for 8'hFF and '^' for CR.
  // Typed rows carry their event by hand; the rest lean on the predictor.
  // ---------------------------------------------------------------------------
  typedef struct {
    string   text;
    bit      fault;
    bit      typed;
    result_t want;
  } stim_row_t;

  stim_row_t rows[$];

  function automatic void add_row(string s, bit flt, bit typed, event_kind_t k,
                                  int unsigned a, int unsigned m, int unsigned e);
    stim_row_t row;
    row.text      = s;
    row.fault     = flt;
    row.typed     = typed;
    row.want      = '0;
    row.want.kind = k;
    row.want.adc  = a[15:0];
    row.want.mv   = m[15:0];
    row.want.err  = e;
    rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall pattern that switches mode every so often, plus the
  // in-order checker. Both read out_stall as it stood at this edge.
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int mode_left  = 0;
  int pat_cnt    = 0;

  function automatic void compare_field(string name, longint unsigned want,
                                        longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (events_due.size() == 0) begin
        $display("%0t: unexpected event, kind %0d error_count %0d",
                 $time, event_kind, error_count);
        mismatches++;
      end else begin
        want = events_due.pop_front();
        compare_field("event_kind", want.kind, event_kind);
        compare_field("adc_value", want.adc, adc_value);
        compare_field("millivolt_value", want.mv, millivolt_value);
        compare_field("record_flag", want.rec, record_flag);
        compare_field("error_count", want.err, error_count);
      end
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(40, 200);
    end else begin
      mode_left--;
    end
    pat_cnt++;
    case (stall_mode)
      0:       out_stall <= 1'b0;                        // free flow
      1:       out_stall <= ($urandom_range(0, 1) == 1);  // coin flip
      2:       out_stall <= ((pat_cnt % 7) < 3);          // periodic
      default: out_stall <= ($urandom_range(0, 9) < 8);   // heavy backpressure
    endcase
  end

  // Watchdog: too long without any transfer on any channel ends the run.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("uart_adc_millivolt_line_parser regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] c;
    string      long_txt;
    string      full_txt;
    int         base;
    logic       rec_val;

    start_line();
    err_tally = '0;
    rec_on    = 1'b0;

    // fault right after reset, then empty lines, then the value extremes
    add_row("~", 1'b1, 1'b1, EV_RX_FAULT, 0, 0, 0);
    add_row("\n", 1'b0, 1'b0, EV_SAMPLE, 0, 0, 0);
    add_row("^", 1'b0, 1'b0, EV_SAMPLE, 0, 0, 0);
    add_row("ADC=0,MV=0\n", 1'b0, 1'b1, EV_SAMPLE, 0, 0, 0);
    add_row("ADC=65535,MV=65535^", 1'b0, 1'b1, EV_SAMPLE, 65535, 65535, 0);
    // saturation on either field
    add_row("ADC=65536,MV=1\n", 1'b0, 1'b1, EV_MALFORMED, 0, 0, 1);
    add_row("ADC=1,MV=99999999\n", 1'b0, 1'b1, EV_MALFORMED, 0, 0, 2);
    // leading zeros, NUL after a full MV field, ignored tail
    add_row("ADC=00012,MV=007#x=\n", 1'b0, 1'b0, EV_SAMPLE, 0, 0, 0);
    // NUL anywhere else breaks the line
    add_row("ADC=5#,MV=5\n", 1'b0, 1'b1, EV_MALFORMED, 0, 0, 3);
    // empty digit fields
    add_row("ADC=,MV=1\n", 1'b0, 1'b1, EV_MALFORMED, 0, 0, 4);
    add_row("ADC=1,MV=\n", 1'b0, 1'b1, EV_MALFORMED, 0, 0, 5);
    // signs, spaces, lower case
    add_row("ADC=+1,MV=-2\n", 1'b0, 1'b1, EV_MALFORMED, 0, 0, 6);
    add_row("ADC=1, MV=2 \n", 1'b0, 1'b1, EV_MALFORMED, 0, 0, 7);
    add_row("adc=1,MV=2\n", 1'b0, 1'b1, EV_MALFORMED, 0, 0, 8);
    // faulted LF in mid line is dropped and does not end the line
    add_row("ADC=12", 1'b0, 1'b0, EV_SAMPLE, 0, 0, 0);
    add_row("\n", 1'b1, 1'b1, EV_RX_FAULT, 0, 0, 8);
    add_row(",MV=3\n", 1'b0, 1'b0, EV_SAMPLE, 0, 0, 0);
    // top byte value, lone NUL line, CR LF pair
    add_row("ADC=1~,MV=2\n", 1'b0, 1'b1, EV_MALFORMED, 0, 0, 9);
    add_row("#\n", 1'b0, 1'b1, EV_MALFORMED, 0, 0, 10);
    add_row("ADC=3,MV=4^\n", 1'b0, 1'b0, EV_SAMPLE, 0, 0, 0);
    // overlong line, then a lone LF that finds an empty line
    long_txt = "ADC=";
    repeat (LINE_LIMIT - 4) long_txt = {long_txt, "9"};
    add_row(long_txt, 1'b0, 1'b1, EV_TOO_LONG, 0, 0, 11);
    add_row("\n", 1'b0, 1'b0, EV_SAMPLE, 0, 0, 0);
    // longest line that still fits
    full_txt = "ADC=1,MV=";
    repeat (LINE_LIMIT - 1 - 9) full_txt = {full_txt, "0"};
    add_row({full_txt, "\n"}, 1'b0, 1'b0, EV_SAMPLE, 0, 0, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    write_recording(1'b0);

    foreach (rows[i]) begin
      for (int j = 0; j < rows[i].text.len(); j++) begin
        c = rows[i].text[j];
        if (c == "#") c = CH_NUL;
        else if (c == "~") c = 8'hFF;
        else if (c == "^") c = CH_CR;
        send_byte(c, rows[i].fault, rows[i].typed, rows[i].want);
      end
    end
    drain_events();

    // Random phases, each under its own recording setting; both extremes
    // come first, the rest are drawn.
    base = items_sent;
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 0) rec_val = 1'b1;
      else if (p == 1) rec_val = 1'b0;
      else rec_val = 1'($urandom_range(0, 1));
      write_recording(rec_val);
      while (items_sent < base + (p + 1) * (RANDOM_ITEMS / NUM_PHASES)) begin
        build_line();
        foreach (line_buf[k]) begin
          // sprinkle receive faults between bytes
          if ($urandom_range(0, 39) == 0) begin
            send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
          end
          send_byte(line_buf[k], 1'b0, 1'b0, '0);
        end
      end
      drain_events();
    end

    if (mismatches == 0) begin
      $display("uart_adc_millivolt_line_parser regression: pass");
    end else begin
      $display("uart_adc_millivolt_line_parser regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/uadc_pkg.sv
design/uadc_parse.sv
design/uart_adc_millivolt_line_parser.sv
bench/testbench.sv
